@@ rtl/acrs_pkg.sv @@
// ----------------------------------------------------------------------------
// acrs_pkg
// types and constants shared by the alias channel remap search block
// ----------------------------------------------------------------------------
package acrs_pkg;

    localparam int CH_W        = 10;
    localparam int FREQ_W      = 16;
    localparam int ALIAS_DEPTH = 1024;
    localparam int ALIAS_AW    = 10;

    // request codes
    localparam logic [1:0] REQ_ADD        = 2'd0;
    localparam logic [1:0] REQ_ADD_FINISH = 2'd1;
    localparam logic [1:0] REQ_FINISH     = 2'd2;
    localparam logic [1:0] REQ_NONE       = 2'd3;

    typedef struct packed {
        logic [1:0]      req_type;
        logic [CH_W-1:0] channel;
    } req_item_t;

    typedef struct packed {
        logic [CH_W-1:0]   orig_channel;
        logic [CH_W-1:0]   new_channel;
        logic              flipped;
        logic              has_mapping;
        logic [FREQ_W-1:0] new_sampling_freq;
        logic              error;
        logic              last;
    } result_item_t;

    // fold unit request, response and status
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic [CH_W-1:0] nyq;
    } fold_req_t;

    typedef struct packed {
        logic [CH_W-1:0] fold_pos;
        logic            flip;
    } fold_rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fold_stat_t;

endpackage

@@ rtl/acrs_ram.sv @@
// ----------------------------------------------------------------------------
// acrs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module acrs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/acrs_mod.sv @@
// ----------------------------------------------------------------------------
// acrs_mod
// shared fold unit: restoring remainder by twice the nyquist value, one bit
// per cycle, then folds the remainder into the first band
// ----------------------------------------------------------------------------
module acrs_mod
    import acrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  fold_req_t  req,
    output fold_rsp_t  rsp,
    output fold_stat_t stat
);

    localparam int CNT_W = $clog2(CH_W);

    logic             run_reg, run_next;
    logic             fold_reg, fold_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CH_W-1:0]  dvd_reg, dvd_next;
    logic [CH_W:0]    rem_reg, rem_next;
    logic [CH_W-1:0]  nyq_reg, nyq_next;
    logic [CH_W-1:0]  pos_reg, pos_next;
    logic             flip_reg, flip_next;

    logic [CH_W:0]    fs;
    logic [CH_W+1:0]  trial;
    logic             ge;

    assign fs    = {nyq_reg, 1'b0};
    assign trial = {rem_reg, dvd_reg[CH_W-1]};
    assign ge    = trial >= {1'b0, fs};

    always_comb
    begin
        run_next  = run_reg;
        fold_next = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        nyq_next  = nyq_reg;
        pos_next  = pos_reg;
        flip_next = flip_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dvd_next = req.ch;
            nyq_next = req.nyq;
            rem_next = '0;
        end
        else if (run_reg)
        begin
            rem_next = ge ? (CH_W+1)'(trial - {1'b0, fs}) : trial[CH_W:0];
            dvd_next = {dvd_reg[CH_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(CH_W - 1))
            begin
                run_next  = 1'b0;
                fold_next = 1'b1;
            end
        end
        else if (fold_reg)
        begin
            // remainder above nyquist lands in the mirrored band
            if (rem_reg <= {1'b0, nyq_reg})
            begin
                pos_next  = rem_reg[CH_W-1:0];
                flip_next = 1'b0;
            end
            else
            begin
                pos_next  = CH_W'(fs - rem_reg);
                flip_next = 1'b1;
            end
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fold_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            fold_reg <= fold_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        nyq_reg  <= nyq_next;
        pos_reg  <= pos_next;
        flip_reg <= flip_next;
    end

    assign rsp.fold_pos = pos_reg;
    assign rsp.flip     = flip_reg;
    assign stat.busy    = run_reg | fold_reg;
    assign stat.done    = done_reg;

endmodule

@@ rtl/alias_channel_remap_search.sv @@
// ----------------------------------------------------------------------------
// alias_channel_remap_search
// collects a set of distinct channels and searches for the smallest nyquist
// value at which all channels fold to distinct alias positions
// ----------------------------------------------------------------------------
// steps: an add item reads, then sets its presence bit; a finish item scans up to
//   the max channel, then folds each channel tried in the shared fold unit,
//   failed candidates clear each marked channel through it, results go out one at a time
// throughput: one item at a time, busy high until the last result is out
// reset: after rst_n a clearing pass over every address wipes the presence
//   and alias maps; busy stays high meanwhile, config writes taken
// results are strobed for one cycle, the receiver cannot stall
module alias_channel_remap_search
    import acrs_pkg::*;
#(
    parameter int MAX_CHANNELS  = 64,
    parameter int CHANNEL_RANGE = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_item_t         req,
    input  logic              cfg_we,
    input  logic [FREQ_W-1:0] cfg_wdata,
    output logic              result_valid,
    output result_item_t      result
);

    localparam int PW     = $clog2(CHANNEL_RANGE);
    localparam int LW     = $clog2(MAX_CHANNELS);
    localparam int CW     = $clog2(MAX_CHANNELS + 1);
    localparam int INIT_L = (CHANNEL_RANGE > ALIAS_DEPTH) ? CHANNEL_RANGE : ALIAS_DEPTH;
    localparam int IW     = $clog2(INIT_L);

    // sequencer states
    localparam logic [3:0] ST_INIT = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_ADD  = 4'd2;
    localparam logic [3:0] ST_FIN  = 4'd3;
    localparam logic [3:0] ST_SCAN = 4'd4;
    localparam logic [3:0] ST_EVAL = 4'd5;
    localparam logic [3:0] ST_RD   = 4'd6;
    localparam logic [3:0] ST_GO   = 4'd7;
    localparam logic [3:0] ST_WAIT = 4'd8;
    localparam logic [3:0] ST_CHK  = 4'd9;

    // walk phases over the sorted list
    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_CLEAR  = 2'd1;
    localparam logic [1:0] PH_EMIT   = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [FREQ_W-1:0] sf_reg;
    logic [IW-1:0]     init_reg, init_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CH_W-1:0]   max_reg, max_next;
    logic              err_reg, err_next;
    logic              fin_reg, fin_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [CH_W-1:0]   scan_reg, scan_next;
    logic              sdone_reg, sdone_next;
    logic              svld_reg, svld_next;
    logic [CH_W-1:0]   sd_reg, sd_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     lim_reg, lim_next;
    logic [CH_W-1:0]   nyq_reg, nyq_next;
    logic              rv_reg, rv_next;
    result_item_t      res_reg, res_next;

    // memory ports
    logic              p_we, p_wdata, p_rdata;
    logic [PW-1:0]     p_waddr, p_raddr;
    logic              a_we, a_wdata, a_rdata;
    logic [ALIAS_AW-1:0] a_waddr;
    logic              l_we;
    logic [CH_W-1:0]   l_rdata;

    // fold unit
    logic              u_start;
    fold_req_t         u_req;
    fold_rsp_t         u_rsp;
    fold_stat_t        u_stat;

    logic              bad_set;
    logic [CW-1:0]     idx_inc;

    assign idx_inc = idx_reg + CW'(1);
    assign bad_set = (sf_reg == '0) || err_reg ||
                     ((count_reg != '0) && ({6'd0, max_reg} > (sf_reg >> 1)));

    acrs_ram #(.WIDTH(1), .DEPTH(CHANNEL_RANGE)) u_present (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    acrs_ram #(.WIDTH(1), .DEPTH(ALIAS_DEPTH)) u_alias_used (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (u_rsp.fold_pos),
        .rdata (a_rdata)
    );

    // channels of the set in ascending order
    acrs_ram #(.WIDTH(CH_W), .DEPTH(MAX_CHANNELS)) u_list (
        .clk   (clk),
        .we    (l_we),
        .waddr (LW'(idx_reg)),
        .wdata (sd_reg),
        .raddr (LW'(idx_reg)),
        .rdata (l_rdata)
    );

    assign u_req.ch  = l_rdata;
    assign u_req.nyq = nyq_reg;

    acrs_mod u_fold (
        .clk   (clk),
        .rst_n (rst_n),
        .start (u_start),
        .req   (u_req),
        .rsp   (u_rsp),
        .stat  (u_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        init_next  = init_reg;
        count_next = count_reg;
        max_next   = max_reg;
        err_next   = err_reg;
        fin_next   = fin_reg;
        ch_next    = ch_reg;
        scan_next  = scan_reg;
        sdone_next = sdone_reg;
        svld_next  = 1'b0;
        sd_next    = sd_reg;
        idx_next   = idx_reg;
        lim_next   = lim_reg;
        nyq_next   = nyq_reg;
        rv_next    = 1'b0;
        res_next   = res_reg;
        p_we       = 1'b0;
        p_waddr    = PW'(ch_reg);
        p_wdata    = 1'b0;
        p_raddr    = PW'(req.channel);
        a_we       = 1'b0;
        a_waddr    = u_rsp.fold_pos;
        a_wdata    = 1'b0;
        l_we       = 1'b0;
        u_start    = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                // wipe both maps after reset
                p_we    = 32'(init_reg) < CHANNEL_RANGE;
                p_waddr = PW'(init_reg);
                a_we    = 32'(init_reg) < ALIAS_DEPTH;
                a_waddr = ALIAS_AW'(init_reg);
                init_next = init_reg + IW'(1);
                if (init_reg == IW'(INIT_L - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ch_next  = req.channel;
                    fin_next = req.req_type == REQ_ADD_FINISH;
                    priority if (req.req_type == REQ_FINISH)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (req.req_type == REQ_NONE)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (32'(req.channel) >= CHANNEL_RANGE)
                    begin
                        err_next   = 1'b1;
                        state_next = (req.req_type == REQ_ADD_FINISH) ? ST_FIN : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                // presence bit of ch_reg is on the read port now
                if (!p_rdata)
                begin
                    if (32'(count_reg) >= MAX_CHANNELS)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        p_we       = 1'b1;
                        p_wdata    = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (ch_reg > max_reg)
                        begin
                            max_next = ch_reg;
                        end
                    end
                end
                state_next = fin_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                scan_next  = '0;
                sdone_next = 1'b0;
                idx_next   = '0;
                state_next = (count_reg != '0) ? ST_SCAN : ST_EVAL;
            end
            ST_SCAN:
            begin
                // sweep presence map upward, build sorted list, clear behind
                p_raddr = PW'(scan_reg);
                if (!sdone_reg)
                begin
                    svld_next = 1'b1;
                    sd_next   = scan_reg;
                    if (scan_reg == max_reg)
                    begin
                        sdone_next = 1'b1;
                    end
                    else
                    begin
                        scan_next = scan_reg + CH_W'(1);
                    end
                end
                if (svld_reg)
                begin
                    p_we    = 1'b1;
                    p_waddr = PW'(sd_reg);
                    if (p_rdata && (32'(idx_reg) < MAX_CHANNELS))
                    begin
                        l_we     = 1'b1;
                        idx_next = idx_inc;
                    end
                end
                if (sdone_reg && !svld_reg)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                idx_next   = '0;
                phase_next = PH_SEARCH;
                nyq_next   = CH_W'(count_reg - CW'(1));
                res_next   = '0;
                res_next.last = 1'b1;
                priority if (bad_set)
                begin
                    res_next.error = 1'b1;
                    rv_next        = 1'b1;
                end
                else if (count_reg == '0)
                begin
                    // empty set keeps the original frequency
                    res_next.new_sampling_freq = sf_reg;
                    rv_next                    = 1'b1;
                end
                else if (count_reg == CW'(1))
                begin
                    // a single channel is always the largest one seen
                    res_next.orig_channel      = max_reg;
                    res_next.has_mapping       = 1'b1;
                    res_next.new_sampling_freq = (max_reg > CH_W'(1)) ?
                                                 FREQ_W'(max_reg) : FREQ_W'(1);
                    rv_next                    = 1'b1;
                end
                else
                begin
                    state_next = ST_RD;
                end
                if (state_next != ST_RD)
                begin
                    state_next = ST_IDLE;
                    count_next = '0;
                    max_next   = '0;
                    err_next   = 1'b0;
                end
            end
            ST_RD:
            begin
                state_next = ST_GO;
            end
            ST_GO:
            begin
                u_start    = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (u_stat.done)
                begin
                    unique case (phase_reg)
                        PH_SEARCH:
                        begin
                            state_next = ST_CHK;
                        end
                        PH_CLEAR:
                        begin
                            a_we  = 1'b1;
                            state_next = ST_RD;
                            if (idx_inc == lim_reg)
                            begin
                                idx_next   = '0;
                                nyq_next   = nyq_reg + CH_W'(1);
                                phase_next = PH_SEARCH;
                            end
                            else
                            begin
                                idx_next = idx_inc;
                            end
                        end
                        PH_EMIT:
                        begin
                            a_we = 1'b1;
                            rv_next = 1'b1;
                            res_next.orig_channel      = l_rdata;
                            res_next.new_channel       = u_rsp.fold_pos;
                            res_next.flipped           = u_rsp.flip;
                            res_next.has_mapping       = 1'b1;
                            res_next.new_sampling_freq = FREQ_W'({nyq_reg, 1'b0});
                            res_next.error             = 1'b0;
                            res_next.last              = idx_inc == count_reg;
                            if (idx_inc == count_reg)
                            begin
                                state_next = ST_IDLE;
                                count_next = '0;
                                max_next   = '0;
                                err_next   = 1'b0;
                            end
                            else
                            begin
                                idx_next   = idx_inc;
                                state_next = ST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHK:
            begin
                state_next = ST_RD;
                if (a_rdata)
                begin
                    // collision: undo marks of channels before this one
                    if (idx_reg == '0)
                    begin
                        nyq_next = nyq_reg + CH_W'(1);
                    end
                    else
                    begin
                        lim_next   = idx_reg;
                        idx_next   = '0;
                        phase_next = PH_CLEAR;
                    end
                end
                else
                begin
                    a_we    = 1'b1;
                    a_wdata = 1'b1;
                    if (idx_inc == count_reg)
                    begin
                        idx_next   = '0;
                        phase_next = PH_EMIT;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            phase_reg <= PH_SEARCH;
            sf_reg    <= FREQ_W'(1);
            init_reg  <= '0;
            count_reg <= '0;
            max_reg   <= '0;
            err_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            sdone_reg <= 1'b0;
            svld_reg  <= 1'b0;
            idx_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (cfg_we)
            begin
                sf_reg <= cfg_wdata;
            end
            init_reg  <= init_next;
            count_reg <= count_next;
            max_reg   <= max_next;
            err_reg   <= err_next;
            fin_reg   <= fin_next;
            sdone_reg <= sdone_next;
            svld_reg  <= svld_next;
            idx_reg   <= idx_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        scan_reg <= scan_next;
        sd_reg   <= sd_next;
        lim_reg  <= lim_next;
        nyq_reg  <= nyq_next;
        res_reg  <= res_next;
    end

    assign busy         = state_reg != ST_IDLE;
    assign result_valid = rv_reg;
    assign result       = res_reg;

    // an error or an unmapped result always closes the run
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.error |-> result.last)
        else $error("error item without last");

    a_nomap_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.has_mapping |-> result.last)
        else $error("unmapped item without last");

    // fold unit is quiet whenever the sequencer is idle
    a_fold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !u_stat.busy && !u_stat.done)
        else $error("fold unit active while idle");

endmodule

@@ test/alias_channel_remap_search_check.sv @@
// ----------------------------------------------------------------------------
// alias_channel_remap_search_check
// watches the request, config and result channels, predicts the alias
// mapping of every finished set and compares the results field by field
// ----------------------------------------------------------------------------
module alias_channel_remap_search_check
    import acrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  req_item_t         req,
    input  logic              cfg_we,
    input  logic [FREQ_W-1:0] cfg_wdata,
    input  logic              result_valid,
    input  result_item_t      result,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CH = 64;

    result_item_t      remap_q[$];
    logic [FREQ_W-1:0] fs_reg;
    bit                present[1024];
    int                ch_count;
    int                ch_max;
    bit                overflow;

    assign pending = remap_q.size();

    task automatic clear_set();
        for (int i = 0; i < 1024; i++) present[i] = 0;
        ch_count = 0;
        ch_max   = 0;
        overflow = 0;
    endtask

    function automatic result_item_t mk(int oc, int nc, bit fl, bit hm, int nsf,
                                        bit er, bit la);
        result_item_t r;
        r.orig_channel      = oc[CH_W-1:0];
        r.new_channel       = nc[CH_W-1:0];
        r.flipped           = fl;
        r.has_mapping       = hm;
        r.new_sampling_freq = nsf[FREQ_W-1:0];
        r.error             = er;
        r.last              = la;
        return r;
    endfunction

    // alias position of ch under nyquist value nyq
    function automatic int fold_pos(int ch, int nyq, output bit fl);
        int r;
        r  = ch % (2 * nyq);
        fl = (r > nyq);
        return fl ? 2 * nyq - r : r;
    endfunction

    // search for the smallest collision free nyquist value
    task automatic predict_remap();
        int  chans[$];
        int  nyq;
        int  a;
        bit  ok;
        bit  fl;
        bit  used[1024];
        if (fs_reg == 0 || overflow || (ch_count > 0 && ch_max > fs_reg / 2)) begin
            remap_q.push_back(mk(0, 0, 0, 0, 0, 1, 1));
            return;
        end
        if (ch_count == 0) begin
            remap_q.push_back(mk(0, 0, 0, 0, fs_reg, 0, 1));
            return;
        end
        for (int c = 0; c <= ch_max; c++)
            if (present[c]) chans.push_back(c);
        if (chans.size() == 1) begin
            remap_q.push_back(mk(chans[0], 0, 0, 1, chans[0] > 1 ? chans[0] : 1, 0, 1));
            return;
        end
        nyq = chans.size() - 1;
        forever begin
            ok = 1;
            for (int i = 0; i < 1024; i++) used[i] = 0;
            foreach (chans[i]) begin
                a = fold_pos(chans[i], nyq, fl) & 1023;
                if (used[a]) begin
                    ok = 0;
                    break;
                end
                used[a] = 1;
            end
            if (ok) break;
            nyq++;
        end
        foreach (chans[i]) begin
            a = fold_pos(chans[i], nyq, fl);
            remap_q.push_back(mk(chans[i], a, fl, 1, 2 * nyq, 0, i == chans.size() - 1));
        end
    endtask

    task automatic take_item(req_item_t it);
        int ch;
        ch = it.channel;
        if (it.req_type == REQ_NONE) return;
        if (it.req_type == REQ_ADD || it.req_type == REQ_ADD_FINISH) begin
            if (!present[ch]) begin
                if (ch_count >= MAX_CH) overflow = 1;
                else begin
                    present[ch] = 1;
                    ch_count++;
                    if (ch > ch_max) ch_max = ch;
                end
            end
        end
        if (it.req_type == REQ_ADD) return;
        predict_remap();
        clear_set();
    endtask

    task automatic check_result(result_item_t got);
        result_item_t exp_r;
        if (remap_q.size() == 0) begin
            $display("%0t unexpected result %p", $realtime, got);
            fail_count++;
            return;
        end
        exp_r = remap_q.pop_front();
        if (got.orig_channel !== exp_r.orig_channel ||
            got.new_channel !== exp_r.new_channel ||
            got.flipped !== exp_r.flipped ||
            got.has_mapping !== exp_r.has_mapping ||
            got.new_sampling_freq !== exp_r.new_sampling_freq ||
            got.error !== exp_r.error || got.last !== exp_r.last) begin
            $display("%0t mismatch: expected %p actual %p", $realtime, exp_r, got);
            fail_count++;
        end
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            fs_reg = 1;
            clear_set();
            remap_q.delete();
        end
        else begin
            if (result_valid) check_result(result);
            if (cfg_we) fs_reg = cfg_wdata;
            if (start && !busy) take_item(req);
        end
    end

endmodule

@@ test/alias_channel_remap_search_test.sv @@
// ----------------------------------------------------------------------------
// alias_channel_remap_search_test
// drives channel sets and sampling frequency settings into the remap search
// block; the checker beside it predicts and compares every result item
// ----------------------------------------------------------------------------
module alias_channel_remap_search_test;
    import acrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              start = 0;
    logic              busy;
    req_item_t         req = '0;
    logic              cfg_we = 0;
    logic [FREQ_W-1:0] cfg_wdata = '0;
    logic              result_valid;
    result_item_t      result;
    int                fail_count;
    int                pending;
    int                idle_pct = 0;
    int                sent = 0;

    always #5 clk = ~clk;

    alias_channel_remap_search i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    alias_channel_remap_search_check i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // drive one item at the falling edge and hold it until accepted;
    // busy only moves at rising edges, so sampling it here is race free
    task automatic send(logic [1:0] rt, int ch);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start = 0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        start       = 1;
        req.req_type = rt;
        req.channel  = ch[CH_W-1:0];
        while (busy) @(negedge clk);
        @(negedge clk);
        start = 0;
        sent++;
    endtask

    // wait for all results plus the add latency, then the block is idle
    task automatic drain();
        while (pending != 0 || busy) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_fs(int v);
        drain();
        cfg_we    = 1;
        cfg_wdata = v[FREQ_W-1:0];
        @(negedge clk);
        cfg_we    = 0;
    endtask

    // one set of n adds over [0, span], finished by either request kind
    task automatic random_set(int n, int span);
        for (int i = 0; i < n; i++) begin
            // occasional noise item that the block ignores
            if ($urandom_range(19) == 0) send(REQ_NONE, $urandom_range(1023));
            send(REQ_ADD, $urandom_range(span));
        end
        if ($urandom_range(1)) send(REQ_ADD_FINISH, $urandom_range(span));
        else send(REQ_FINISH, $urandom_range(1023));
    endtask

    task automatic random_phase(int items);
        int target;
        int span;
        int n;
        int pick;
        target = sent + items;
        while (sent < target) begin
            pick = $urandom_range(99);
            // mostly narrow spans keep the search short
            if (pick < 75) span = $urandom_range(63, 3);
            else if (pick < 93) span = $urandom_range(255, 64);
            else span = 1023;
            n = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(5);
            random_set(n, span);
        end
    endtask

    initial begin
        #200ms;
        $display("[alias_channel_remap_search] ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(negedge clk);
        rst_n = 1;
        // config is taken during the clearing pass after reset
        cfg_we    = 1;
        cfg_wdata = 16'hFFFF;
        @(negedge clk);
        cfg_we    = 0;

        // directed part
        send(REQ_FINISH, 0);                 // empty set
        send(REQ_ADD_FINISH, 0);             // single channel 0
        send(REQ_ADD_FINISH, 1023);          // single channel at the top
        send(REQ_ADD, 5);
        send(REQ_ADD, 5);                    // duplicate
        send(REQ_ADD_FINISH, 9);
        send(REQ_ADD, 1023);
        send(REQ_ADD, 682);
        send(REQ_ADD_FINISH, 341);
        send(REQ_NONE, 1023);                // unused request
        send(REQ_ADD, 3);
        send(REQ_ADD, 7);
        send(REQ_FINISH, 1023);
        write_fs(2000);
        send(REQ_ADD, 1001);                 // above half
        send(REQ_ADD_FINISH, 4);
        write_fs(0);
        send(REQ_FINISH, 0);                 // zero sampling frequency
        send(REQ_ADD_FINISH, 1);
        write_fs(1);
        send(REQ_ADD_FINISH, 1);             // single channel 1
        send(REQ_ADD_FINISH, 0);
        write_fs(65535);
        // too many channels
        for (int c = 0; c < 65; c++) send(REQ_ADD, c);
        send(REQ_FINISH, 0);
        // exactly the maximum set
        for (int c = 0; c < 63; c++) send(REQ_ADD, c);
        send(REQ_ADD_FINISH, 63);

        // random part: idle phases times sampling frequency settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 88;
                2: idle_pct = 0;
                default: idle_pct = 18;
            endcase
            write_fs(65535);
            random_phase(20);
            write_fs($urandom_range(2100, 130));
            random_phase(15);
            write_fs($urandom_range(65535));
            random_phase(8);
        end
        idle_pct = 0;
        write_fs(1);
        random_phase(6);

        drain();
        if (fail_count == 0)
            $display("[alias_channel_remap_search] OK");
        else
            $display("[alias_channel_remap_search] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/acrs_pkg.sv
rtl/acrs_ram.sv
rtl/acrs_mod.sv
rtl/alias_channel_remap_search.sv
test/alias_channel_remap_search_check.sv
test/alias_channel_remap_search_test.sv
